// ===== rtl/assert_macros.svh =====
// Assertion macros used by the move_to_front_list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mtf_pkg.sv =====
`default_nettype none

package mtf_pkg;

    localparam int VALUE_W      = 32;
    localparam int POS_W        = 4;
    localparam int CFG_W        = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Operation broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic rotate;
        logic cfg_wr;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/mtf_cell.sv =====
`default_nettype none

module mtf_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mtf_pkg::t_cell_ctl         i_ctl,
    input  wire logic [CNT_W-1:0]           i_cap,
    input  wire logic [mtf_pkg::VALUE_W-1:0] i_key,
    input  wire logic [mtf_pkg::VALUE_W-1:0] i_head_value,
    input  wire logic [mtf_pkg::VALUE_W-1:0] i_prev_value,
    input  wire logic                       i_prev_valid,
    input  wire logic                       i_prev_seen,
    input  wire logic [mtf_pkg::VALUE_W-1:0] i_next_value,
    input  wire logic                       i_next_valid,
    output logic [mtf_pkg::VALUE_W-1:0]     o_value,
    output logic                            o_valid,
    output logic                            o_seen
);
    import mtf_pkg::*;

    localparam logic [CNT_W-1:0] IDX_V = CNT_W'(IDX);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;
    logic               r_valid;
    logic               n_valid;
    logic               w_in_use;
    logic               w_shift;

    assign w_in_use = (IDX_V < i_cap);
    // Take the previous cell's entry while it is valid, this cell is in use and no match has been found in front of it
    assign w_shift  = !i_prev_seen && i_prev_valid && w_in_use;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.cfg_wr) begin
            if (!w_in_use) begin
                n_valid = 1'b0;
            end
        end else if (i_ctl.insert) begin
            if (w_shift) begin
                n_value = i_prev_value;
                n_valid = i_prev_valid;
            end
        end else if (i_ctl.rotate) begin
            // Advance toward the front; the last valid cell wraps the head entry
            if (i_next_valid) begin
                n_value = i_next_value;
            end else if (r_valid) begin
                n_value = i_head_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_seen  = i_prev_seen || (r_valid && (r_value == i_key));

endmodule

`default_nettype wire

// ===== rtl/move_to_front_list.sv =====
// Insert: accepted without raising busy, no result; a new transaction may follow in the next cycle.
// Read-out: busy while in the read state; entries pass from the head cell through the output register in list order.
// Empty list read-out: one invalid result in the cycle after start, busy stays low.
// Read-out rotates the cell chain once around, so the list is unchanged afterwards.
// Synchronous active-low reset empties the list and sets the capacity in use (r_cap) to CAPACITY.
`default_nettype none

module move_to_front_list #(
    parameter int CAPACITY = mtf_pkg::CAPACITY_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_req_type,
    input  wire logic signed [mtf_pkg::VALUE_W-1:0] i_value_in,
    input  wire logic                        i_cfg_we,
    input  wire logic [mtf_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                             o_strobe,
    output logic signed [mtf_pkg::VALUE_W-1:0] o_value_out,
    output logic [mtf_pkg::POS_W-1:0]        o_position,
    output logic                             o_entry_valid,
    output logic                             o_last_item
);
    import mtf_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     r_cap;
    logic [CNT_W-1:0]     n_cap;
    logic [CNT_W-1:0]     r_pos;
    logic [CNT_W-1:0]     n_pos;
    logic                 r_strobe;
    logic                 n_strobe;
    logic [VALUE_W-1:0]   r_value_out;
    logic [VALUE_W-1:0]   n_value_out;
    logic [POS_W-1:0]     r_position;
    logic [POS_W-1:0]     n_position;
    logic                 r_entry_valid;
    logic                 n_entry_valid;
    logic                 r_last_item;
    logic                 n_last_item;

    logic                 w_accept;
    logic                 w_hit;
    logic                 w_last;
    logic [CNT_W-1:0]     w_cfg_cap;
    t_cell_ctl            w_ctl;
    logic [CNT_W-1:0]     w_cell_cap;
    logic [VALUE_W-1:0]   w_value [CAPACITY+1];
    logic [CAPACITY:0]    w_valid;
    logic [CAPACITY:0]    w_seen;

    assign w_accept = start && !busy;

    // Saturate the written capacity into 1..CAPACITY
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg_cap = CNT_W'(1);
        end else if (32'(i_cfg_wdata) > CAPACITY) begin
            w_cfg_cap = CAP_MAX;
        end else begin
            w_cfg_cap = CNT_W'(i_cfg_wdata);
        end
    end

    assign w_ctl.insert = w_accept && (i_req_type == REQ_INSERT);
    assign w_ctl.rotate = (r_state == ST_READ);
    assign w_ctl.cfg_wr = i_cfg_we;
    assign w_cell_cap   = i_cfg_we ? w_cfg_cap : r_cap;

    assign w_value[CAPACITY] = '0;
    assign w_valid[CAPACITY] = 1'b0;
    assign w_seen[0]         = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [VALUE_W-1:0] w_prev_value;
            logic               w_prev_valid;
            if (g == 0) begin : g_head
                assign w_prev_value = i_value_in;
                assign w_prev_valid = 1'b1;
            end else begin : g_body
                assign w_prev_value = w_value[g-1];
                assign w_prev_valid = w_valid[g-1];
            end
            mtf_cell #(
                .CNT_W (CNT_W),
                .IDX   (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_cap        (w_cell_cap),
                .i_key        (i_value_in),
                .i_head_value (w_value[0]),
                .i_prev_value (w_prev_value),
                .i_prev_valid (w_prev_valid),
                .i_prev_seen  (w_seen[g]),
                .i_next_value (w_value[g+1]),
                .i_next_valid (w_valid[g+1]),
                .o_value      (w_value[g]),
                .o_valid      (w_valid[g]),
                .o_seen       (w_seen[g+1])
            );
        end
    endgenerate

    assign w_hit  = w_seen[CAPACITY];
    assign w_last = ((r_pos + CNT_W'(1)) == r_count);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_cap         = r_cap;
        n_pos         = r_pos;
        n_strobe      = 1'b0;
        n_value_out   = r_value_out;
        n_position    = r_position;
        n_entry_valid = r_entry_valid;
        n_last_item   = r_last_item;

        if (i_cfg_we) begin
            n_cap = w_cfg_cap;
            if (r_count > w_cfg_cap) begin
                n_count = w_cfg_cap;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_INSERT) begin
                        if (!w_hit && (r_count < r_cap)) begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_strobe      = 1'b1;
                        n_value_out   = '0;
                        n_position    = '0;
                        n_entry_valid = 1'b0;
                        n_last_item   = 1'b1;
                    end else begin
                        n_pos   = '0;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_strobe      = 1'b1;
                n_value_out   = w_value[0];
                n_position    = POS_W'(r_pos);
                n_entry_valid = 1'b1;
                n_last_item   = w_last;
                n_pos         = r_pos + CNT_W'(1);
                if (w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pos         <= n_pos;
        r_value_out   <= n_value_out;
        r_position    <= n_position;
        r_entry_valid <= n_entry_valid;
        r_last_item   <= n_last_item;
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_cap    <= CAP_MAX;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cap    <= n_cap;
            r_strobe <= n_strobe;
        end
    end

    assign busy          = (r_state == ST_READ);
    assign o_strobe      = r_strobe;
    assign o_value_out   = r_value_out;
    assign o_position    = r_position;
    assign o_entry_valid = r_entry_valid;
    assign o_last_item   = r_last_item;

    `ASSERT_ALWAYS(a_count_le_cap, i_clk, i_rst_n, r_count <= r_cap, "count exceeds capacity")
    `ASSERT_ALWAYS(a_valid_matches_count, i_clk, i_rst_n, CNT_W'($countones(w_valid[CAPACITY-1:0])) == r_count, "cell valid bits disagree with count")
    `ASSERT_IMPLIES(a_read_nonempty, i_clk, i_rst_n, busy, r_count != '0, "read-out running on an empty list")
    `ASSERT_IMPLIES(a_empty_is_last, i_clk, i_rst_n, o_strobe && !o_entry_valid, o_last_item && (o_value_out == '0), "invalid result not a final zero item")
    `ASSERT_NEXT(a_last_ends_read, i_clk, i_rst_n, busy && w_last, !busy && o_strobe && o_last_item, "read-out did not end on the last entry")

endmodule

`default_nettype wire
